FILE: design/sha256_hash_engine_defines.svh
// Assertion macros shared by the hash engine modules.
`ifndef SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA256_HASH_ENGINE_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define SHA_ASSERT_IMPL(lbl, clk_s, rst_s, cond, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |-> (cons)) \
    else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define SHA_ASSERT_NEXT(lbl, clk_s, rst_s, cond, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sha_pkg.sv
`default_nettype none

package sha_pkg;

  // One classified item (a byte, an end mark or both) passed from the front part to the core.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } sha_item_t;

  localparam int QueueDepth = 4;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  // Round constants.
  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  // Initial hash values.
  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: design/sha_front.sv
`default_nettype none
`include "sha256_hash_engine_defines.svh"

// Front part: takes stream transfers, drops idle items and queues the rest.
module sha_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [7:0]         s_tdata,
  input  wire logic               s_tuser,
  input  wire logic               s_tlast,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output sha_pkg::sha_item_t      q_item
);
  import sha_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  sha_item_t           fifo [QueueDepth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [PtrW:0]       count;
  logic                push;
  logic                pop;

  assign s_tready = (count != (PtrW+1)'(QueueDepth));
  // Items with neither a byte nor an end mark have no effect and are not queued.
  assign push = s_tvalid && s_tready && (s_tuser || s_tlast);
  assign q_valid = (count != '0);
  assign pop = q_valid && q_ready;
  assign q_item = fifo[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{data_byte: s_tdata, has_byte: s_tuser, last: s_tlast};
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  // The queue never overflows or underflows.
  `SHA_ASSERT_IMPL(a_push_room, clk, rst, push, count != (PtrW+1)'(QueueDepth), "push into full queue")
  `SHA_ASSERT_IMPL(a_pop_data, clk, rst, pop, count != '0, "pop from empty queue")

endmodule

`default_nettype wire

FILE: design/sha_core.sv
`default_nettype none
`include "sha256_hash_engine_defines.svh"

// Back part: buffers bytes, pads, runs one round per cycle and emits the digest.
module sha_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire sha_pkg::sha_item_t q_item,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [31:0]             m_tdata,
  output logic [2:0]              m_tuser,
  output logic                    m_tlast
);
  import sha_pkg::*;

  localparam logic [2:0] StFill  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StAdd   = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0]   state;
  logic [5:0]   fill;
  logic [60:0]  byte_total;
  logic         fin_pend;   // the final byte filled the block, padding follows it
  logic         in_pad;     // the block under way is completed by padding
  logic         pad_first;  // the 0x80 marker is still owed
  logic         len_here;   // the padded block under way carries the length
  logic [31:0]  hw [8];
  logic [31:0]  v [8];
  logic [31:0]  w [16];
  logic [5:0]   rnd;
  logic [2:0]   out_idx;
  logic [63:0]  bits;
  logic [7:0]   pad_val;
  logic [7:0]   shift_byte;
  logic         shift_en;
  logic [31:0]  wt, t1, t2, s0, s1, w15, w2, wn;
  logic         byte_in;

  assign bits = {byte_total, 3'b000};
  assign q_ready = (state == StFill);
  assign byte_in = q_valid && q_ready;
  assign shift_en = (byte_in && q_item.has_byte) || (state == StPad);
  assign shift_byte = (state == StPad) ? pad_val : q_item.data_byte;

  // Padding byte for the current fill position.
  always_comb begin
    if (pad_first) pad_val = PadByte;
    else if (len_here && fill >= LenPos) pad_val = bits[{3'd7 - fill[2:0], 3'b000} +: 8];
    else pad_val = 8'h00;
  end

  // Schedule word for the current round.
  always_comb begin
    w15 = w[1];
    w2 = w[14];
    s0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
    s1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
    wn = w[0] + s0 + w[9] + s1;
    wt = (rnd < 6'd16) ? w[0] : wn;
    t1 = v[7] + ({v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]}
         ^ {v[4][24:0], v[4][31:25]}) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
         + round_k(rnd) + wt;
    t2 = ({v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]}
         ^ {v[0][21:0], v[0][31:22]}) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // Block window: bytes shift in at the low end, big-endian, so after 64 of
  // them w[0] holds the first word. During the rounds the same window rotates
  // as the rolling 16-word message schedule.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) w[i] <= {w[i][23:0], w[i+1][31:24]};
      w[15] <= {w[15][23:0], shift_byte};
    end else if (state == StRound) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wt;
    end
  end

  // Control and working variables.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StFill;
      fill <= '0;
      byte_total <= '0;
      fin_pend <= 1'b0;
      in_pad <= 1'b0;
      pad_first <= 1'b0;
      len_here <= 1'b0;
      rnd <= '0;
      out_idx <= '0;
      for (int i = 0; i < 8; i++) hw[i] <= init_h(3'(i));
    end else begin
      unique case (state)
        StFill: begin
          if (byte_in) begin
            if (q_item.has_byte) begin
              fill <= fill + 1'b1;
              byte_total <= byte_total + 1'b1;
            end
            if (q_item.has_byte && fill == 6'd63) begin
              // The block is full; a final byte leaves padding for later.
              fin_pend <= q_item.last;
              rnd <= '0;
              state <= StRound;
              for (int i = 0; i < 8; i++) v[i] <= hw[i];
            end else if (q_item.last) begin
              in_pad <= 1'b1;
              pad_first <= 1'b1;
              state <= StPad;
            end
          end
        end
        StPad: begin
          fill <= fill + 1'b1;
          if (pad_first) begin
            // The length fits only if the marker lands before its field.
            pad_first <= 1'b0;
            len_here <= (fill < LenPos);
          end
          if (fill == 6'd63) begin
            rnd <= '0;
            state <= StRound;
            for (int i = 0; i < 8; i++) v[i] <= hw[i];
          end
        end
        StRound: begin
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          rnd <= rnd + 1'b1;
          if (rnd == 6'd63) state <= StAdd;
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) hw[i] <= hw[i] + v[i];
          if (in_pad && len_here) begin
            out_idx <= '0;
            state <= StOut;
          end else if (in_pad) begin
            // The marker left no room for the length: one more block.
            len_here <= 1'b1;
            state <= StPad;
          end else if (fin_pend) begin
            // A full block ended the message: the marker opens the next one.
            fin_pend <= 1'b0;
            in_pad <= 1'b1;
            pad_first <= 1'b1;
            state <= StPad;
          end else begin
            state <= StFill;
          end
        end
        StOut: begin
          if (m_tready) begin
            out_idx <= out_idx + 1'b1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) hw[i] <= init_h(3'(i));
              byte_total <= '0;
              in_pad <= 1'b0;
              state <= StFill;
            end
          end
        end
        default: state <= StFill;
      endcase
    end
  end

  assign m_tvalid = (state == StOut);
  assign m_tdata = hw[out_idx];
  assign m_tuser = out_idx;
  assign m_tlast = (out_idx == 3'd7);

  // A stalled digest transfer holds, and no input is taken while it is out.
  `SHA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tuser), "digest transfer dropped while stalled")
  `SHA_ASSERT_NEXT(a_word_hold, clk, rst, m_tvalid && !m_tready, $stable(m_tdata), "digest word changed while stalled")
  `SHA_ASSERT_IMPL(a_ready_idle, clk, rst, q_ready, !m_tvalid, "input taken while digest is out")

endmodule

`default_nettype wire

FILE: design/sha256_hash_engine.sv
// SHA-256 engine over a byte stream. Each accepted transfer on s_ carries one
// byte (tuser = 1) or only an end mark (tuser = 0, tlast = 1); the transfer with
// tlast set closes the message, after which padding is added and the digest
// leaves on m_ as eight 32-bit words, word 0 first, tlast on word 7. Bytes go
// through a four-entry queue and shift into the block window at one per cycle
// while the core is filling a block; each full 64-byte block then runs the 64
// rounds (one round per cycle in a single compression unit) and an add step,
// during which no byte is taken, with input held off once the queue is full.
// The message end shifts in padding at one byte per cycle to close the block,
// runs the rounds and the add for each padded block, up to two of them, and is
// followed by the eight digest transfers, during which no input is taken.
`default_nettype none

module sha256_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte
  input  wire logic        s_tuser,   // has_byte
  input  wire logic        s_tlast,   // last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // digest_word
  output logic [2:0]       m_tuser,   // word_index
  output logic             m_tlast    // last_word
);
  import sha_pkg::*;

  logic      q_valid;
  logic      q_ready;
  sha_item_t q_item;

  sha_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .q_valid, .q_ready, .q_item
  );

  sha_core u_core (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

endmodule

`default_nettype wire
